>>> rtl/core/two_level_cache_with_victim_macros.svh
// assertion macros used by the checker file of the cache hierarchy
// no dependencies; include once per file that asserts
`ifndef TWO_LEVEL_CACHE_WITH_VICTIM_MACROS_SVH
`define TWO_LEVEL_CACHE_WITH_VICTIM_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TLCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tlcv_pkg.sv
// geometry, row types, command structs and address helpers of the cache hierarchy
// no dependencies; used by every other file of the block but the macros header
package tlcv_pkg;

  localparam int BLOCK_BITS   = 4;
  localparam int L1_SIZE_BITS = 12;
  localparam int L1_WAY_BITS  = 1;
  localparam int L2_SIZE_BITS = 15;
  localparam int L2_WAY_BITS  = 2;
  localparam int VICTIM_DEPTH = 4;

  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CYC_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int LVL_W     = 2;

  localparam int L1_SET_W  = L1_SIZE_BITS - BLOCK_BITS - L1_WAY_BITS;
  localparam int L2_SET_W  = L2_SIZE_BITS - BLOCK_BITS - L2_WAY_BITS;
  localparam int L1_TAG_W  = ADDR_W - BLOCK_BITS - L1_SET_W;
  localparam int L2_TAG_W  = ADDR_W - BLOCK_BITS - L2_SET_W;
  localparam int VIC_TAG_W = ADDR_W - BLOCK_BITS;
  localparam int L1_WAYS   = 1 << L1_WAY_BITS;
  localparam int L2_WAYS   = 1 << L2_WAY_BITS;
  localparam int L1_SETS   = 1 << L1_SET_W;
  localparam int L2_SETS   = 1 << L2_SET_W;
  localparam int L1_CNT_W  = $clog2(L1_WAYS + 1);
  localparam int L2_CNT_W  = $clog2(L2_WAYS + 1);
  localparam int VIC_CNT_W = $clog2(VICTIM_DEPTH + 1);
  localparam int L1_IDX_W  = (L1_WAY_BITS > 0) ? L1_WAY_BITS : 1;
  localparam int L2_IDX_W  = (L2_WAY_BITS > 0) ? L2_WAY_BITS : 1;
  localparam int VIC_IDX_W = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
  localparam int CLR_W     = (L2_SET_W > L1_SET_W) ? L2_SET_W : L1_SET_W;
  localparam int CLR_ROWS  = 1 << CLR_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CYCLES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_CYCLES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_CYCLES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_CYCLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_EN     = 3'd5;

  // hit level codes
  localparam logic [LVL_W-1:0] LVL_L1  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_L2  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_VIC = 2'd2;
  localparam logic [LVL_W-1:0] LVL_MEM = 2'd3;

  // one set is a list in recency order: way 0 least recent, n lines valid
  typedef struct packed {
    logic [L1_TAG_W-1:0] tag;
    logic                dirty;
  } l1_ent_t;

  typedef struct packed {
    l1_ent_t [L1_WAYS-1:0] w;
    logic [L1_CNT_W-1:0]   n;
  } l1_row_t;

  typedef struct packed {
    logic [L2_TAG_W-1:0] tag;
    logic                dirty;
  } l2_ent_t;

  typedef struct packed {
    l2_ent_t [L2_WAYS-1:0] w;
    logic [L2_CNT_W-1:0]   n;
  } l2_row_t;

  // victim buffer in age order: entry 0 oldest
  typedef struct packed {
    logic [VIC_TAG_W-1:0] tag;
    logic                 dirty;
  } vic_ent_t;

  typedef struct packed {
    vic_ent_t [VICTIM_DEPTH-1:0] w;
    logic [VIC_CNT_W-1:0]        n;
  } vic_row_t;

  // controller to datapath
  typedef struct packed {
    logic             clr;
    logic [CLR_W-1:0] clr_idx;
    logic             accept;
    logic             look;
    logic             fill2;
    logic             fill1;
    logic             wr;
    logic             wb;
    logic             load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wb_pend;
    logic out_free;
  } sts_t;

  function automatic logic [L1_SET_W-1:0] l1_set_f(input logic [ADDR_W-1:0] a);
    return a[BLOCK_BITS +: L1_SET_W];
  endfunction

  function automatic logic [L1_TAG_W-1:0] l1_tag_f(input logic [ADDR_W-1:0] a);
    return a[ADDR_W-1 -: L1_TAG_W];
  endfunction

  function automatic logic [L2_SET_W-1:0] l2_set_f(input logic [ADDR_W-1:0] a);
    return a[BLOCK_BITS +: L2_SET_W];
  endfunction

  function automatic logic [L2_TAG_W-1:0] l2_tag_f(input logic [ADDR_W-1:0] a);
    return a[ADDR_W-1 -: L2_TAG_W];
  endfunction

  function automatic logic [VIC_TAG_W-1:0] vic_tag_f(input logic [ADDR_W-1:0] a);
    return a[ADDR_W-1 -: VIC_TAG_W];
  endfunction

endpackage

>>> rtl/core/tlcv_if.sv
// valid/ready channel interfaces for access requests and access results
// depends on tlcv_pkg for payload widths
interface tlcv_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [tlcv_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

interface tlcv_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tlcv_pkg::LVL_W-1:0]    hit_level;
  logic [tlcv_pkg::CYC_W-1:0]    access_cycles;
  logic                          l1_miss;
  logic                          l2_miss;

  modport source (output valid, output hit_level, output access_cycles, output l1_miss,
                  output l2_miss, input ready);
  modport sink   (input valid, input hit_level, input access_cycles, input l1_miss,
                  input l2_miss, output ready);
endinterface

>>> rtl/core/tlcv_ctrl.sv
// sequencing state machine of the cache hierarchy: clearing pass, then one access at a time
// depends on tlcv_pkg for the command and status structs
module tlcv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  tlcv_pkg::sts_t sts_i,
  output tlcv_pkg::cmd_t cmd_o
);
  import tlcv_pkg::*;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_FILL2 = 3'd3;
  localparam logic [2:0] ST_FILL1 = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr     = 1'b1;
        cmd_o.clr_idx = clr_cnt_q;
        clr_cnt_d     = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(CLR_ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_FILL2;
      end
      ST_FILL2: begin
        cmd_o.fill2 = 1'b1;
        state_d     = ST_FILL1;
      end
      ST_FILL1: begin
        cmd_o.fill1 = 1'b1;
        state_d     = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.wb_pend ? ST_WB : ST_FIN;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

>>> rtl/core/tlcv_dp.sv
// datapath of the cache hierarchy: set memories, working rows, victim buffer, result register
// depends on tlcv_pkg; driven by tlcv_ctrl commands
module tlcv_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlcv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlcv_pkg::CFG_W-1:0]      cfg_data_i,
  input  tlcv_pkg::cmd_t                  cmd_i,
  output tlcv_pkg::sts_t                  sts_o,
  input  logic                            in_action_i,
  input  logic [tlcv_pkg::ADDR_W-1:0]     in_address_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [tlcv_pkg::LVL_W-1:0]      out_hit_level_o,
  output logic [tlcv_pkg::CYC_W-1:0]      out_access_cycles_o,
  output logic                            out_l1_miss_o,
  output logic                            out_l2_miss_o
);
  import tlcv_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [L1_IDX_W-1:0] idx;
  } l1_hit_t;

  typedef struct packed {
    logic                hit;
    logic [L2_IDX_W-1:0] idx;
  } l2_hit_t;

  typedef struct packed {
    logic                 hit;
    logic [VIC_IDX_W-1:0] idx;
  } vic_hit_t;

  // list helpers: lowest matching position wins
  function automatic l1_hit_t l1_find(input l1_row_t r, input logic [L1_TAG_W-1:0] t);
    l1_hit_t res;
    res = '0;
    for (int j = L1_WAYS - 1; j >= 0; j--) begin
      if (j < int'(r.n) && r.w[j].tag == t) begin
        res.hit = 1'b1;
        res.idx = L1_IDX_W'(j);
      end
    end
    return res;
  endfunction

  function automatic l1_row_t l1_mru(input l1_row_t r, input logic [L1_IDX_W-1:0] i);
    l1_row_t o;
    l1_ent_t t;
    o = r;
    t = r.w[i];
    for (int j = 0; j < L1_WAYS; j++) begin
      if (j >= int'(i) && j + 1 < int'(r.n)) o.w[j] = r.w[j+1];
      else if (j + 1 == int'(r.n)) o.w[j] = t;
    end
    return o;
  endfunction

  function automatic l1_row_t l1_del(input l1_row_t r, input logic [L1_IDX_W-1:0] i);
    l1_row_t o;
    o = r;
    for (int j = 0; j < L1_WAYS; j++) begin
      if (j >= int'(i) && j + 1 < int'(r.n)) o.w[j] = r.w[j+1];
    end
    o.n = r.n - L1_CNT_W'(1);
    return o;
  endfunction

  function automatic l1_row_t l1_ins(input l1_row_t r, input logic [L1_TAG_W-1:0] t,
                                     input logic d);
    l1_row_t b;
    l1_row_t o;
    b = r;
    if (int'(r.n) == L1_WAYS) begin
      for (int j = 0; j < L1_WAYS - 1; j++) b.w[j] = r.w[j+1];
      b.n = L1_CNT_W'(L1_WAYS - 1);
    end
    o = b;
    for (int j = 0; j < L1_WAYS; j++) begin
      if (j == int'(b.n)) begin
        o.w[j].tag   = t;
        o.w[j].dirty = d;
      end
    end
    o.n = b.n + L1_CNT_W'(1);
    return o;
  endfunction

  function automatic l2_hit_t l2_find(input l2_row_t r, input logic [L2_TAG_W-1:0] t);
    l2_hit_t res;
    res = '0;
    for (int j = L2_WAYS - 1; j >= 0; j--) begin
      if (j < int'(r.n) && r.w[j].tag == t) begin
        res.hit = 1'b1;
        res.idx = L2_IDX_W'(j);
      end
    end
    return res;
  endfunction

  function automatic l2_row_t l2_mru(input l2_row_t r, input logic [L2_IDX_W-1:0] i);
    l2_row_t o;
    l2_ent_t t;
    o = r;
    t = r.w[i];
    for (int j = 0; j < L2_WAYS; j++) begin
      if (j >= int'(i) && j + 1 < int'(r.n)) o.w[j] = r.w[j+1];
      else if (j + 1 == int'(r.n)) o.w[j] = t;
    end
    return o;
  endfunction

  function automatic l2_row_t l2_ins(input l2_row_t r, input logic [L2_TAG_W-1:0] t,
                                     input logic d);
    l2_row_t b;
    l2_row_t o;
    b = r;
    if (int'(r.n) == L2_WAYS) begin
      for (int j = 0; j < L2_WAYS - 1; j++) b.w[j] = r.w[j+1];
      b.n = L2_CNT_W'(L2_WAYS - 1);
    end
    o = b;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (j == int'(b.n)) begin
        o.w[j].tag   = t;
        o.w[j].dirty = d;
      end
    end
    o.n = b.n + L2_CNT_W'(1);
    return o;
  endfunction

  // dirty writeback into a second-level set: mark dirty and most recent
  function automatic l2_row_t l2_wback(input l2_row_t r, input logic [L2_TAG_W-1:0] t);
    l2_row_t o;
    l2_hit_t h;
    o = r;
    h = l2_find(r, t);
    if (h.hit) begin
      o.w[h.idx].dirty = 1'b1;
      o = l2_mru(o, h.idx);
    end
    return o;
  endfunction

  function automatic vic_hit_t vic_find(input vic_row_t r, input logic [VIC_TAG_W-1:0] t);
    vic_hit_t res;
    res = '0;
    for (int j = VICTIM_DEPTH - 1; j >= 0; j--) begin
      if (j < int'(r.n) && r.w[j].tag == t) begin
        res.hit = 1'b1;
        res.idx = VIC_IDX_W'(j);
      end
    end
    return res;
  endfunction

  function automatic vic_row_t vic_del(input vic_row_t r, input logic [VIC_IDX_W-1:0] i);
    vic_row_t o;
    o = r;
    for (int j = 0; j < VICTIM_DEPTH; j++) begin
      if (j >= int'(i) && j + 1 < int'(r.n)) o.w[j] = r.w[j+1];
    end
    o.n = r.n - VIC_CNT_W'(1);
    return o;
  endfunction

  function automatic vic_row_t vic_ins(input vic_row_t r, input logic [VIC_TAG_W-1:0] t,
                                       input logic d);
    vic_row_t b;
    vic_row_t o;
    b = r;
    if (int'(r.n) >= VICTIM_DEPTH) begin
      for (int j = 0; j < VICTIM_DEPTH - 1; j++) b.w[j] = r.w[j+1];
      b.n = VIC_CNT_W'(VICTIM_DEPTH - 1);
    end
    o = b;
    for (int j = 0; j < VICTIM_DEPTH; j++) begin
      if (j == int'(b.n)) begin
        o.w[j].tag   = t;
        o.w[j].dirty = d;
      end
    end
    o.n = b.n + VIC_CNT_W'(1);
    return o;
  endfunction

  // configuration
  logic [CFG_W-1:0] mem_cyc_q, l1_cyc_q, l2_cyc_q, vic_cyc_q;
  logic             walloc_q, ven_q;

  // set memories and their read registers
  l1_row_t l1_mem [L1_SETS];
  l2_row_t l2_mem [L2_SETS];
  l1_row_t l1_rd_q;
  l2_row_t l2_rd_q;

  // current transaction and working rows
  logic              act_q;
  logic [ADDR_W-1:0] addr_q;
  l1_row_t           l1w_q, l1w_d;
  l2_row_t           l2w_q, l2w_d;
  vic_row_t          vic_q, vic_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [CYC_W-1:0]  cyc_q, cyc_d;
  logic              m1_q, m1_d, m2_q, m2_d;
  logic              fdirty_q, fdirty_d, dofill_q, dofill_d, dol2_q, dol2_d;
  logic              wb_pend_q, wb_pend_d;
  logic [ADDR_W-1:0] wa_q, wa_d;

  // lookup and fill intermediates
  l1_hit_t           h1, he;
  l2_hit_t           h2, hc;
  vic_hit_t          hv;
  l1_row_t           r1;
  l2_row_t           r2, t2;
  l1_ent_t           ev1;
  l2_ent_t           ev2;
  logic              lk_dirty, d1, wb_need, wb_same;
  logic [ADDR_W-1:0] ea, wb_addr;

  // memory write controls
  logic                l1_we, l2_we;
  logic [L1_SET_W-1:0] l1_waddr;
  logic [L2_SET_W-1:0] l2_waddr;
  l1_row_t             l1_wdat;
  l2_row_t             l2_wdat;
  l2_row_t             wb_row;

  // result register
  logic              out_valid_q;
  logic [LVL_W-1:0]  out_lvl_q;
  logic [CYC_W-1:0]  out_cyc_q;
  logic              out_m1_q, out_m2_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_cyc_q <= CFG_W'(100);
      l1_cyc_q  <= CFG_W'(1);
      l2_cyc_q  <= CFG_W'(5);
      vic_cyc_q <= CFG_W'(1);
      walloc_q  <= 1'b1;
      ven_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEM_CYCLES:    mem_cyc_q <= cfg_data_i;
        CFG_L1_CYCLES:     l1_cyc_q  <= cfg_data_i;
        CFG_L2_CYCLES:     l2_cyc_q  <= cfg_data_i;
        CFG_VICTIM_CYCLES: vic_cyc_q <= cfg_data_i;
        CFG_WRITE_ALLOC:   walloc_q  <= cfg_data_i[0];
        CFG_VICTIM_EN:     ven_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // working state update for lookup and both fill steps
  always_comb begin
    l1w_d     = l1w_q;
    l2w_d     = l2w_q;
    vic_d     = vic_q;
    level_d   = level_q;
    cyc_d     = cyc_q;
    m1_d      = m1_q;
    m2_d      = m2_q;
    fdirty_d  = fdirty_q;
    dofill_d  = dofill_q;
    dol2_d    = dol2_q;
    wb_pend_d = wb_pend_q;
    wa_d      = wa_q;
    h1        = l1_find(l1_rd_q, l1_tag_f(addr_q));
    h2        = l2_find(l2_rd_q, l2_tag_f(addr_q));
    hv        = vic_find(vic_q, vic_tag_f(addr_q));
    r1        = l1_rd_q;
    r2        = l2_rd_q;
    lk_dirty  = 1'b0;
    ev2       = l2w_q.w[0];
    ea        = {ev2.tag, l2_set_f(addr_q), BLOCK_BITS'(0)};
    he        = l1_find(l1w_q, l1_tag_f(ea));
    d1        = 1'b0;
    ev1       = l1w_q.w[0];
    wb_addr   = {ev1.tag, l1_set_f(addr_q), BLOCK_BITS'(0)};
    wb_need   = (int'(l1w_q.n) == L1_WAYS) && ev1.dirty;
    wb_same   = l2_set_f(wb_addr) == l2_set_f(addr_q);
    t2        = l2w_q;
    hc        = '0;

    // lookup through the levels, charging each one tried
    if (cmd_i.look) begin
      l1w_d     = l1_rd_q;
      l2w_d     = l2_rd_q;
      level_d   = LVL_MEM;
      cyc_d     = CYC_W'(l1_cyc_q);
      wb_pend_d = 1'b0;
      if (h1.hit) begin
        if (act_q) r1.w[h1.idx].dirty = 1'b1;
        l1w_d   = l1_mru(r1, h1.idx);
        level_d = LVL_L1;
      end else begin
        cyc_d = cyc_d + CYC_W'(l2_cyc_q);
        if (h2.hit) begin
          if (act_q) r2.w[h2.idx].dirty = 1'b1;
          lk_dirty = r2.w[h2.idx].dirty;
          l2w_d    = l2_mru(r2, h2.idx);
          level_d  = LVL_L2;
        end else begin
          if (ven_q) begin
            cyc_d = cyc_d + CYC_W'(vic_cyc_q);
            if (hv.hit) begin
              lk_dirty = vic_q.w[hv.idx].dirty;
              if (act_q && !walloc_q) begin
                vic_d.w[hv.idx].dirty = 1'b1;
                lk_dirty              = 1'b1;
              end else begin
                vic_d = vic_del(vic_q, hv.idx);
              end
              level_d = LVL_VIC;
            end
          end
          if (level_d == LVL_MEM) cyc_d = cyc_d + CYC_W'(mem_cyc_q);
        end
      end
      m1_d     = !h1.hit;
      m2_d     = !h1.hit && !h2.hit;
      fdirty_d = act_q ? 1'b1 : lk_dirty;
      dofill_d = (!act_q || walloc_q) && (level_d != LVL_L1);
      dol2_d   = (!act_q || walloc_q) && (level_d != LVL_L1) && (level_d != LVL_L2);
    end

    // second-level fill, snooping an evicted line out of the first level
    if (cmd_i.fill2 && dol2_q) begin
      l2w_d = l2_ins(l2w_q, l2_tag_f(addr_q), 1'b0);
      if (int'(l2w_q.n) == L2_WAYS) begin
        if (he.hit) begin
          d1    = l1w_q.w[he.idx].dirty;
          l1w_d = l1_del(l1w_q, he.idx);
        end
        if (ven_q) vic_d = vic_ins(vic_q, vic_tag_f(ea), d1 || ev2.dirty);
      end
    end

    // first-level fill, writeback of a dirty eviction within the same second-level set, clean the second-level copy
    if (cmd_i.fill1 && dofill_q) begin
      l1w_d = l1_ins(l1w_q, l1_tag_f(addr_q), fdirty_q);
      if (wb_need && wb_same) t2 = l2_wback(l2w_q, l2_tag_f(wb_addr));
      hc = l2_find(t2, l2_tag_f(addr_q));
      if (hc.hit) t2.w[hc.idx].dirty = 1'b0;
      l2w_d     = t2;
      wb_pend_d = wb_need && !wb_same;
      wa_d      = wb_addr;
    end
  end

  // writeback row for a dirty eviction that lands in another second-level set
  assign wb_row = l2_wback(l2_rd_q, l2_tag_f(wa_q));

  // memory write selection
  always_comb begin
    l1_we    = cmd_i.clr || cmd_i.wr;
    l1_waddr = cmd_i.clr ? cmd_i.clr_idx[L1_SET_W-1:0] : l1_set_f(addr_q);
    l1_wdat  = cmd_i.clr ? l1_row_t'('0) : l1w_q;
    l2_we    = cmd_i.clr || cmd_i.wr || cmd_i.wb;
    priority if (cmd_i.clr) begin
      l2_waddr = cmd_i.clr_idx[L2_SET_W-1:0];
      l2_wdat  = '0;
    end else if (cmd_i.wr) begin
      l2_waddr = l2_set_f(addr_q);
      l2_wdat  = l2w_q;
    end else begin
      l2_waddr = l2_set_f(wa_q);
      l2_wdat  = wb_row;
    end
  end

  // first-level set memory
  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[l1_waddr] <= l1_wdat;
    if (cmd_i.accept) l1_rd_q <= l1_mem[l1_set_f(in_address_i)];
  end

  // second-level set memory
  always_ff @(posedge clk_i) begin
    if (l2_we) l2_mem[l2_waddr] <= l2_wdat;
    if (cmd_i.accept) l2_rd_q <= l2_mem[l2_set_f(in_address_i)];
    else if (cmd_i.wr) l2_rd_q <= l2_mem[l2_set_f(wa_q)];
  end

  // transaction and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= in_action_i;
      addr_q <= in_address_i;
    end
    l1w_q     <= l1w_d;
    l2w_q     <= l2w_d;
    level_q   <= level_d;
    cyc_q     <= cyc_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    fdirty_q  <= fdirty_d;
    dofill_q  <= dofill_d;
    dol2_q    <= dol2_d;
    wb_pend_q <= wb_pend_d;
    wa_q      <= wa_d;
  end

  // victim buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vic_q <= '0;
    else         vic_q <= vic_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_lvl_q <= level_q;
      out_cyc_q <= cyc_q;
      out_m1_q  <= m1_q;
      out_m2_q  <= m2_q;
    end
  end

  assign sts_o.wb_pend        = wb_pend_q;
  assign sts_o.out_free       = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_hit_level_o      = out_lvl_q;
  assign out_access_cycles_o  = out_cyc_q;
  assign out_l1_miss_o        = out_m1_q;
  assign out_l2_miss_o        = out_m2_q;

endmodule

>>> rtl/core/two_level_cache_with_victim.sv
// top level of the two-level inclusive cache timing model with victim buffer
// depends on tlcv_pkg, tlcv_if, tlcv_ctrl and tlcv_dp
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, address
//   rsp_o    out  valid/ready    hit_level, access_cycles, l1_miss, l2_miss
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// an access runs from accept through the lookup, second-level fill, first-level fill and
// write states to the result register load; the next accept follows that load; a dirty
// first-level eviction written back to another second-level set adds a writeback state
// after reset a clearing pass over 512 rows empties the set memories; no request is taken
// a result waiting on rsp_o lets the next access be taken and run; that one then waits
// to load its result until rsp_o is free
module two_level_cache_with_victim (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tlcv_pkg::CFG_W-1:0]     cfg_data_i,
  tlcv_req_if.sink                       req_i,
  tlcv_rsp_if.source                     rsp_o
);
  import tlcv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tlcv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // set memories, victim buffer and result register
  tlcv_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_action_i         (req_i.action),
    .in_address_i        (req_i.address),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .out_hit_level_o     (rsp_o.hit_level),
    .out_access_cycles_o (rsp_o.access_cycles),
    .out_l1_miss_o       (rsp_o.l1_miss),
    .out_l2_miss_o       (rsp_o.l2_miss)
  );

endmodule

>>> rtl/core/tlcv_checker.sv
// port-level checks of the cache hierarchy, attached to the top level by bind
// depends on tlcv_pkg and the assertion macros header
`include "two_level_cache_with_victim_macros.svh"

module tlcv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tlcv_pkg::LVL_W-1:0]    out_hit_level_i,
  input logic                          out_l1_miss_i,
  input logic                          out_l2_miss_i
);
  import tlcv_pkg::*;

  // a first-level hit reports no miss at all
  `TLCV_ASSERT_NOW(a_l1_hit_flags, out_valid_i && out_hit_level_i == LVL_L1, !out_l1_miss_i && !out_l2_miss_i, "l1 hit with miss flag")
  // a second-level hit missed only the first level
  `TLCV_ASSERT_NOW(a_l2_hit_flags, out_valid_i && out_hit_level_i == LVL_L2, out_l1_miss_i && !out_l2_miss_i, "l2 hit with wrong miss flags")
  // victim and memory answers missed both levels
  `TLCV_ASSERT_NOW(a_far_hit_flags, out_valid_i && (out_hit_level_i == LVL_VIC || out_hit_level_i == LVL_MEM), out_l1_miss_i && out_l2_miss_i, "far hit without both misses")
  // one access in work at a time
  `TLCV_ASSERT_NEXT(a_one_in_work, in_valid_i && in_ready_i, !in_ready_i, "request taken while busy")
  // a stalled result stays offered
  `TLCV_ASSERT_NEXT(a_rsp_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped under stall")

endmodule

bind two_level_cache_with_victim tlcv_checker u_tlcv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .out_hit_level_i (rsp_o.hit_level),
  .out_l1_miss_i   (rsp_o.l1_miss),
  .out_l2_miss_i   (rsp_o.l2_miss)
);
